>>> hdl/mlfq_scheduler_engine_macros.svh
// Assertion helpers for the scheduler engine
`ifndef MLFQ_SCHEDULER_ENGINE_MACROS_SVH
`define MLFQ_SCHEDULER_ENGINE_MACROS_SVH

// Implication checked in the next cycle
`define MLFQS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication checked in the same cycle
`define MLFQS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> hdl/mlfqs_pkg.sv
`default_nettype none
package mlfqs_pkg;

	localparam int MAX_THREADS = 16;
	localparam int SLOT_W      = 4;
	localparam int FRAC_BITS   = 14;
	localparam logic signed [31:0] FP_ONE = 32'sd1 <<< FRAC_BITS;
	// 59/60 and 1/60 in fixed point, truncated
	localparam logic signed [31:0] C59 = 32'((59 * (64'sd1 <<< FRAC_BITS)) / 60);
	localparam logic signed [31:0] C1  = 32'((64'sd1 <<< FRAC_BITS) / 60);

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_CREATE = 3'd1,
		CMD_EXIT   = 3'd2,
		CMD_NICE   = 3'd3,
		CMD_READY  = 3'd4,
		CMD_PICK   = 3'd5,
		CMD_QUERY  = 3'd6,
		CMD_SPARE  = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		CFG_TPS    = 3'd0,
		CFG_SLICE  = 3'd1,
		CFG_RECALC = 3'd2,
		CFG_PMAX   = 3'd3,
		CFG_PMIN   = 3'd4
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_TICK, ST_LA_M1, ST_LA_M2, ST_LA_M3, ST_LA_DS, ST_LA_DW,
		ST_DEC_MUL, ST_DEC_WR, ST_RECALC, ST_RUNRD, ST_CREATE, ST_MKRDY,
		ST_NICE, ST_EXIT, ST_PICK, ST_PICK_WR, ST_OUT
	} state_t;

	// Product of two fixed-point values, truncated toward zero, wrapped to 32 bits
	function automatic logic signed [31:0] fp_scale(input logic signed [63:0] p);
		logic signed [63:0] t;
		logic signed [63:0] sh;
		t  = p + (p[63] ? 64'((64'sd1 <<< FRAC_BITS) - 1) : 64'sd0);
		sh = t >>> FRAC_BITS;
		return sh[31:0];
	endfunction

	// Value times 100, wrapped, then integer part truncated toward zero
	function automatic logic signed [31:0] fp_x100(input logic signed [31:0] v);
		logic signed [31:0] m;
		logic signed [32:0] t;
		logic signed [32:0] sh;
		m  = v * 32'sd100;
		t  = {m[31], m} + (m[31] ? 33'((33'sd1 <<< FRAC_BITS) - 1) : 33'sd0);
		sh = t >>> FRAC_BITS;
		return sh[31:0];
	endfunction

	// pri_max - cpu_usage/4 - 2*nice, capped at pri_max then raised to pri_min
	function automatic logic [7:0] calc_pri(input logic signed [31:0] rc,
			input logic signed [5:0] nice, input logic [7:0] pmax, input logic [7:0] pmin);
		logic signed [32:0] t;
		logic signed [32:0] q;
		logic signed [35:0] p;
		t = {rc[31], rc} + (rc[31] ? 33'((33'sd1 <<< (FRAC_BITS + 2)) - 1) : 33'sd0);
		q = t >>> (FRAC_BITS + 2);
		p = $signed({28'd0, pmax}) - 36'(q) - 36'(nice) - 36'(nice);
		if (p > $signed({28'd0, pmax}))
			p = $signed({28'd0, pmax});
		if (p < $signed({28'd0, pmin}))
			p = $signed({28'd0, pmin});
		return p[7:0];
	endfunction

endpackage
`default_nettype wire

>>> hdl/mlfqs_div.sv
`default_nettype none
// Restoring divider: (a << FRAC_BITS) / b, truncated toward zero, one bit a cycle
module mlfqs_div
	import mlfqs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output logic                    done,
	output logic signed [31:0]      q
);
	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [31:0]   rem_q;
	logic [31:0]   den_q;
	logic          neg_q;
	logic          zero_q;
	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [32:0]   trial;
	logic          fits;
	logic [31:0]   mag_a;
	logic [31:0]   mag_b;
	logic [31:0]   qneg;

	assign mag_a = a[31] ? 32'(-a) : a;
	assign mag_b = b[31] ? 32'(-b) : b;
	assign trial = {rem_q, num_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign qneg  = -num_q[31:0];

	// Iterate one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q  <= {mag_a, FRAC_BITS'(0)};
			rem_q  <= '0;
			den_q  <= mag_b;
			neg_q  <= a[31] ^ b[31];
			zero_q <= (b == 32'sd0);
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			num_q <= {num_q[NW-2:0], fits};
		end
	end

	// Apply sign, wrap to 32 bits; a zero divisor gives zero
	always_comb begin
		if (zero_q)
			q = '0;
		else if (neg_q)
			q = qneg;
		else
			q = num_q[31:0];
	end
endmodule
`default_nettype wire

>>> hdl/mlfq_scheduler_engine.sv
`default_nettype none
// Query goes straight to output; exit and set nice touch one slot; create and make ready
// first read the running slot, then write; pick walks every slot. A plain tick updates counters;
// one that ends a second also updates the load average through the 46-step divider and then
// decays recent CPU slot by slot; a due recompute walks every slot to refresh priorities.
// One command at a time: the next may transfer in the done cycle; done is high one cycle.
// arst_n clears control state, slot flags, counters, load average and registers to defaults.
module mlfq_scheduler_engine
	import mlfqs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [2:0]        cmd,
	input  wire logic [3:0]        slot,
	input  wire logic [3:0]        running_slot,
	input  wire logic              running_idle,
	input  wire logic signed [5:0] nice_value,
	output logic                   done,
	output logic [3:0]             selected_slot,
	output logic                   none_ready,
	output logic                   yield_request,
	output logic [7:0]             priority_out,
	output logic signed [31:0]     recent_cpu_x100,
	output logic signed [31:0]     load_avg_x100,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [9:0]        cfg_data
);
	`include "mlfq_scheduler_engine_macros.svh"

	state_t state_q, state_d;

	// configuration
	logic [9:0] tps_q;
	logic [7:0] slice_ticks_q, pmax_q, pmin_q;
	logic [4:0] rperiod_q;

	// slot table
	logic                    valid_q [MAX_THREADS];
	logic                    ready_q [MAX_THREADS];
	logic signed [5:0]       nice_q  [MAX_THREADS];
	logic signed [31:0]      rc_q    [MAX_THREADS];
	logic [7:0]              pri_q   [MAX_THREADS];
	logic [15:0]             stamp_q [MAX_THREADS];

	logic [15:0]        stamp_cnt_q;
	logic signed [31:0] load_q;
	logic [9:0]         second_q;
	logic [3:0]         recalc_q;
	logic [7:0]         slice_q;

	// latched command
	cmd_t              cmd_q;
	logic [3:0]        slot_q, run_q;
	logic              idle_q;
	logic signed [5:0] nv_q;

	logic [SLOT_W-1:0] idx_q;
	logic              recalc_go_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] acc_q, coeff_q;
	logic signed [5:0]  src_nice_q;
	logic signed [31:0] src_rc_q;
	logic [7:0]         run_pri_q;
	logic               run_ok_q;
	logic               best_ok_q;
	logic [3:0]         best_q;
	logic [7:0]         best_pri_q;
	logic [15:0]        best_age_q;

	// read port, one address a cycle
	logic [SLOT_W-1:0]  rd_idx;
	logic               r_valid, r_ready;
	logic signed [5:0]  r_nice;
	logic signed [31:0] r_rc;
	logic [7:0]         r_pri;
	logic [15:0]        r_age;

	logic signed [31:0] mul_a, mul_b;
	logic               div_go, div_done;
	logic signed [31:0] div_q, two_x;
	logic [4:0]         ready_cnt;
	logic [4:0]         period;
	logic [4:0]         recalc_nx;
	logic [10:0]        second_nx;
	logic [7:0]         slice_nx;
	logic               last_idx;
	logic signed [5:0]  nv_clamp;
	logic [7:0]         new_pri;
	logic               pick_better;
	logic [MAX_THREADS-1:0] rdy_vec;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);

	always_comb begin
		case (state_q)
			ST_RUNRD:                                  rd_idx = run_q;
			ST_DEC_MUL, ST_DEC_WR, ST_RECALC, ST_PICK: rd_idx = idx_q;
			default:                                   rd_idx = slot_q;
		endcase
	end

	assign r_valid = valid_q[rd_idx];
	assign r_ready = ready_q[rd_idx];
	assign r_nice  = nice_q[rd_idx];
	assign r_rc    = rc_q[rd_idx];
	assign r_pri   = pri_q[rd_idx];
	assign r_age   = stamp_cnt_q - stamp_q[rd_idx];

	always_comb begin
		for (int i = 0; i < MAX_THREADS; i++)
			rdy_vec[i] = valid_q[i] & ready_q[i];
	end
	assign ready_cnt = 5'($countones(rdy_vec)) + {4'd0, ~idle_q};

	assign two_x     = 32'(load_q <<< 1);
	assign period    = (rperiod_q > 5'd16) ? 5'd16 : rperiod_q;
	assign recalc_nx = {1'b0, recalc_q} + 5'd1;
	assign second_nx = {1'b0, second_q} + 11'd1;
	assign slice_nx  = (slice_q == 8'hFF) ? slice_q : slice_q + 8'd1;
	assign last_idx  = (idx_q == SLOT_W'(MAX_THREADS - 1));
	assign nv_clamp  = (nv_q < -6'sd20) ? -6'sd20 : ((nv_q > 6'sd20) ? 6'sd20 : nv_q);
	assign new_pri   = calc_pri(r_rc, nv_clamp, pmax_q, pmin_q);
	assign pick_better = r_valid && r_ready && (!best_ok_q || r_pri > best_pri_q ||
		(r_pri == best_pri_q && r_age > best_age_q));

	// Shared multiplier operands
	always_comb begin
		case (state_q)
			ST_LA_M1: begin
				mul_a = C59;
				mul_b = load_q;
			end
			ST_LA_M2: begin
				mul_a = C1;
				mul_b = 32'(signed'({1'b0, ready_cnt}) <<< FRAC_BITS);
			end
			default: begin
				mul_a = coeff_q;
				mul_b = r_rc;
			end
		endcase
	end

	assign div_go = (state_q == ST_LA_DS);

	mlfqs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.a      (two_x),
		.b      (32'(two_x + FP_ONE)),
		.done   (div_done),
		.q      (div_q)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd_t'(cmd))
						CMD_TICK:   state_d = ST_TICK;
						CMD_CREATE: state_d = ST_RUNRD;
						CMD_READY:  state_d = ST_RUNRD;
						CMD_EXIT:   state_d = ST_EXIT;
						CMD_NICE:   state_d = ST_NICE;
						CMD_PICK:   state_d = ST_PICK;
						default:    state_d = ST_OUT;
					endcase
				end
			end
			ST_TICK: begin
				if (second_nx >= {1'b0, tps_q})
					state_d = ST_LA_M1;
				else if (recalc_nx >= period)
					state_d = ST_RECALC;
				else
					state_d = ST_OUT;
			end
			ST_LA_M1:   state_d = ST_LA_M2;
			ST_LA_M2:   state_d = ST_LA_M3;
			ST_LA_M3:   state_d = ST_LA_DS;
			ST_LA_DS:   state_d = ST_LA_DW;
			ST_LA_DW:   if (div_done) state_d = ST_DEC_MUL;
			ST_DEC_MUL: state_d = ST_DEC_WR;
			ST_DEC_WR: begin
				if (!last_idx)
					state_d = ST_DEC_MUL;
				else if (recalc_go_q)
					state_d = ST_RECALC;
				else
					state_d = ST_OUT;
			end
			ST_RECALC:  if (last_idx) state_d = ST_OUT;
			ST_RUNRD:   state_d = (cmd_q == CMD_CREATE) ? ST_CREATE : ST_MKRDY;
			ST_CREATE:  state_d = ST_OUT;
			ST_MKRDY:   state_d = ST_OUT;
			ST_NICE:    state_d = ST_OUT;
			ST_EXIT:    state_d = ST_OUT;
			ST_PICK:    if (last_idx) state_d = ST_PICK_WR;
			ST_PICK_WR: state_d = ST_OUT;
			ST_OUT:     state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q         <= 10'd100;
			slice_ticks_q <= 8'd4;
			rperiod_q     <= 5'd4;
			pmax_q        <= 8'd63;
			pmin_q        <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TPS:    tps_q         <= cfg_data;
				CFG_SLICE:  slice_ticks_q <= cfg_data[7:0];
				CFG_RECALC: rperiod_q     <= cfg_data[4:0];
				CFG_PMAX:   pmax_q        <= cfg_data[7:0];
				CFG_PMIN:   pmin_q        <= cfg_data[7:0];
				default:    ;
			endcase
		end
	end

	// Control state: flags, counters, load average, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_THREADS; i++) begin
				valid_q[i] <= 1'b0;
				ready_q[i] <= 1'b0;
			end
			stamp_cnt_q <= '0;
			load_q      <= '0;
			second_q    <= '0;
			recalc_q    <= '0;
			slice_q     <= '0;
			done        <= 1'b0;
		end else begin
			done <= (state_q == ST_OUT);
			case (state_q)
				ST_TICK: begin
					second_q <= (second_nx >= {1'b0, tps_q}) ? 10'd0 : second_nx[9:0];
					recalc_q <= (recalc_nx >= period) ? 4'd0 : recalc_nx[3:0];
					slice_q  <= slice_nx;
				end
				ST_LA_M3: load_q <= 32'(acc_q + fp_scale(prod_q));
				ST_CREATE: begin
					valid_q[slot_q] <= 1'b1;
					ready_q[slot_q] <= 1'b1;
					stamp_cnt_q     <= stamp_cnt_q + 16'd1;
				end
				ST_MKRDY: begin
					if (r_valid && !r_ready) begin
						ready_q[slot_q] <= 1'b1;
						stamp_cnt_q     <= stamp_cnt_q + 16'd1;
					end
				end
				ST_EXIT: begin
					valid_q[slot_q] <= 1'b0;
					ready_q[slot_q] <= 1'b0;
				end
				ST_PICK_WR: begin
					if (best_ok_q)
						ready_q[best_q] <= 1'b0;
					slice_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Datapath and table payload
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q         <= cmd_t'(cmd);
					slot_q        <= slot;
					run_q         <= running_slot;
					idle_q        <= running_idle;
					nv_q          <= nice_value;
					idx_q         <= '0;
					best_ok_q     <= 1'b0;
					selected_slot <= '0;
					none_ready    <= 1'b0;
					yield_request <= 1'b0;
				end
			end
			ST_TICK: begin
				if (!idle_q && valid_q[run_q])
					rc_q[run_q] <= 32'(rc_q[run_q] + FP_ONE);
				recalc_go_q   <= (recalc_nx >= period);
				yield_request <= (slice_nx >= slice_ticks_q);
				idx_q         <= '0;
			end
			ST_LA_M2: acc_q <= fp_scale(prod_q);
			ST_LA_DW: if (div_done) coeff_q <= div_q;
			ST_DEC_WR: begin
				if (r_valid)
					rc_q[idx_q] <= 32'(fp_scale(prod_q) + (32'(r_nice) <<< FRAC_BITS));
				idx_q <= last_idx ? '0 : idx_q + 1'b1;
			end
			ST_RECALC: begin
				if (r_valid)
					pri_q[idx_q] <= calc_pri(r_rc, r_nice, pmax_q, pmin_q);
				idx_q <= idx_q + 1'b1;
			end
			ST_RUNRD: begin
				run_ok_q   <= !idle_q && r_valid;
				src_nice_q <= (!idle_q && r_valid) ? r_nice : 6'sd0;
				src_rc_q   <= (!idle_q && r_valid) ? r_rc : 32'sd0;
				run_pri_q  <= r_pri;
			end
			ST_CREATE: begin
				nice_q[slot_q]  <= src_nice_q;
				rc_q[slot_q]    <= src_rc_q;
				pri_q[slot_q]   <= calc_pri(src_rc_q, src_nice_q, pmax_q, pmin_q);
				stamp_q[slot_q] <= stamp_cnt_q;
				yield_request   <= run_ok_q && (slot_q != run_q) &&
					(calc_pri(src_rc_q, src_nice_q, pmax_q, pmin_q) > run_pri_q);
			end
			ST_MKRDY: begin
				if (r_valid && !r_ready) begin
					stamp_q[slot_q] <= stamp_cnt_q;
					yield_request   <= run_ok_q && (r_pri > run_pri_q);
				end
			end
			ST_NICE: begin
				if (r_valid) begin
					nice_q[slot_q] <= nv_clamp;
					pri_q[slot_q]  <= new_pri;
					yield_request  <= !idle_q && (run_q == slot_q) && (new_pri < r_pri);
				end
			end
			ST_PICK: begin
				if (pick_better) begin
					best_ok_q  <= 1'b1;
					best_q     <= 4'(idx_q);
					best_pri_q <= r_pri;
					best_age_q <= r_age;
				end
				idx_q <= idx_q + 1'b1;
			end
			ST_PICK_WR: begin
				selected_slot <= best_ok_q ? best_q : 4'd0;
				none_ready    <= !best_ok_q;
			end
			ST_OUT: begin
				priority_out    <= r_valid ? r_pri : 8'd0;
				recent_cpu_x100 <= r_valid ? fp_x100(r_rc) : 32'sd0;
				load_avg_x100   <= fp_x100(load_q);
			end
			default: ;
		endcase
	end

	`MLFQS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not raise busy")
	`MLFQS_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
	`MLFQS_ASSERT_NOW(a_none_sel, done && none_ready, selected_slot == 4'd0,
		"empty pick reported a slot")
	`MLFQS_ASSERT_NEXT(a_out_done, state_q == ST_OUT, done && !busy,
		"result not delivered after output state")
endmodule
`default_nettype wire
